### rtl/core/bsls_pkg.sv
// Shared types and constants for the bounded sorted list store.
// Command, result and cell control structs; used by bsls_cell and the top level.
package bsls_pkg;

    localparam int DATA_W = 32;
    localparam int OCC_W  = 5;

    localparam logic [2:0] OP_HEAD_INS   = 3'd0;
    localparam logic [2:0] OP_TAIL_INS   = 3'd1;
    localparam logic [2:0] OP_SORT_INS   = 3'd2;
    localparam logic [2:0] OP_REMOVE     = 3'd3;
    localparam logic [2:0] OP_SORT_REM   = 3'd4;
    localparam logic [2:0] OP_DUMP       = 3'd5;

    typedef struct packed {
        logic [2:0]               opcode;
        logic signed [DATA_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] element;
        logic                     found;
        logic                     rejected;
        logic                     empty_res;
        logic [OCC_W-1:0]         occupancy;
        logic                     last;
    } res_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INS_HEAD,
        CELL_INS_TAIL,
        CELL_INS_SORT,
        CELL_MARK_ALL,
        CELL_MARK_SORT,
        CELL_COMPACT,
        CELL_ROTATE
    } cell_op_t;

    typedef struct packed {
        cell_op_t                 op;
        logic signed [DATA_W-1:0] value;
    } cell_ctl_t;

    typedef struct packed {
        logic first;
        logic ins;
        logic doom;
        logic run;
        logic head;
        logic beyond;
        logic stop;
    } chain_t;

    localparam chain_t CHAIN_SEED = '{first: 1'b1, ins: 1'b0, doom: 1'b0, run: 1'b1,
                                      head: 1'b0, beyond: 1'b0, stop: 1'b0};

endpackage

### rtl/core/bsls_cell.sv
// One storage cell of the list chain: holds one word and its removal mark.
// Depends on bsls_pkg for the control and chain structs.
module bsls_cell (
    input  logic                              clk,
    input  logic                              rst_n,
    input  bsls_pkg::cell_ctl_t               ctl,
    input  logic                              valid,
    input  logic                              at_count,
    input  logic                              tail_pos,
    input  logic signed [bsls_pkg::DATA_W-1:0] left_data,
    input  logic signed [bsls_pkg::DATA_W-1:0] right_data,
    input  logic                              right_doom,
    input  logic signed [bsls_pkg::DATA_W-1:0] head_data,
    input  bsls_pkg::chain_t                  chain_in,
    output bsls_pkg::chain_t                  chain_out,
    output logic signed [bsls_pkg::DATA_W-1:0] data,
    output logic                              doom
);
    import bsls_pkg::*;

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;
    logic                     doom_reg;
    logic                     doom_next;
    logic                     eq;
    logic                     gt;
    logic                     ge;
    logic                     hit;
    logic                     del_sort;
    logic                     pre_doom;

    assign eq       = (data_reg == ctl.value);
    assign gt       = (data_reg > ctl.value);
    assign ge       = (data_reg >= ctl.value);
    assign del_sort = valid & eq & (chain_in.run | chain_in.head |
                                    (chain_in.beyond & ~chain_in.stop));
    assign pre_doom = chain_in.doom | doom_reg;

    always_comb
    begin
        case (ctl.op)
            CELL_INS_HEAD: hit = chain_in.first;
            CELL_INS_TAIL: hit = at_count;
            CELL_INS_SORT: hit = (valid & ge) | at_count;
            default:       hit = 1'b0;
        endcase
    end

    always_comb
    begin
        chain_out.first  = 1'b0;
        chain_out.ins    = chain_in.ins | hit;
        chain_out.doom   = pre_doom;
        chain_out.run    = chain_in.run & eq;
        chain_out.head   = chain_in.run & ~eq;
        chain_out.beyond = chain_in.beyond | chain_in.head;
        chain_out.stop   = chain_in.stop | (chain_in.beyond & gt);
    end

    always_comb
    begin
        data_next = data_reg;
        doom_next = 1'b0;
        case (ctl.op)
            CELL_INS_HEAD, CELL_INS_TAIL, CELL_INS_SORT:
            begin
                if (chain_in.ins)
                    data_next = left_data;
                else if (hit)
                    data_next = ctl.value;
            end
            CELL_MARK_ALL:  doom_next = valid & eq;
            CELL_MARK_SORT: doom_next = del_sort;
            CELL_COMPACT:
            begin
                if (pre_doom)
                begin
                    data_next = right_data;
                    doom_next = right_doom;
                end
            end
            CELL_ROTATE:    data_next = tail_pos ? head_data : right_data;
            default:        data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            doom_reg <= 1'b0;
        else
            doom_reg <= doom_next;
    end

    assign data = data_reg;
    assign doom = doom_reg;

endmodule

### rtl/core/bounded_sorted_list_store.sv
// Bounded sorted list store: a chain of DEPTH bsls_cell words plus the command sequencer.
// Depends on bsls_pkg and bsls_cell. The receiver cannot stall results.
// Inserts, unused opcodes, empty dump: result in the next cycle, next start taken at once.
// Removes: busy in S_COMPACT until no mark is left, then result and next start together.
// Dump: busy in S_DUMP, results on consecutive cycles from the rotating head word.
// Reset clears the element count; stored words are undefined until written.
module bounded_sorted_list_store #(
    parameter int DEPTH = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  bsls_pkg::cmd_t   cmd,
    output logic             busy,
    output logic             result_valid,
    output bsls_pkg::res_t   result
);
    import bsls_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE    = 3'b001,
        S_COMPACT = 3'b010,
        S_DUMP    = 3'b100
    } state_t;

    state_t                   state_reg, state_next;
    logic [CW-1:0]            count_reg, count_next;
    logic [CW-1:0]            dcnt_reg, dcnt_next;
    logic                     found_reg, found_next;
    logic                     rv_reg, rv_next;
    res_t                     res_reg, res_next;
    cell_ctl_t                ctl;
    logic                     accept;
    logic                     full;
    logic [CW-1:0]            tail_idx;

    logic signed [DATA_W-1:0] cell_data [DEPTH];
    logic                     cell_doom [DEPTH];
    chain_t                   chain [DEPTH+1];

    function automatic res_t make_res(input logic signed [DATA_W-1:0] elem,
                                      input logic fnd, input logic rej,
                                      input logic [CW-1:0] cnt, input logic lst);
        res_t          r;
        logic [CW+OCC_W-1:0] ext;
        ext         = {{OCC_W{1'b0}}, cnt};
        r.element   = elem;
        r.found     = fnd;
        r.rejected  = rej;
        r.empty_res = (cnt == '0);
        r.occupancy = ext[OCC_W-1:0];
        r.last      = lst;
        return r;
    endfunction

    assign accept   = start & (state_reg == S_IDLE);
    assign full     = (count_reg == CW'(DEPTH));
    assign tail_idx = count_reg - CW'(1);
    assign chain[0] = CHAIN_SEED;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic signed [DATA_W-1:0] left_w;
            logic signed [DATA_W-1:0] right_w;
            logic                     rdoom_w;
            if (gi == 0)
            begin : g_first
                assign left_w = ctl.value;
            end
            else
            begin : g_mid
                assign left_w = cell_data[gi-1];
            end
            if (gi == DEPTH - 1)
            begin : g_end
                assign right_w = cell_data[gi];
                assign rdoom_w = 1'b0;
            end
            else
            begin : g_inner
                assign right_w = cell_data[gi+1];
                assign rdoom_w = cell_doom[gi+1];
            end
            bsls_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .valid      (CW'(gi) < count_reg),
                .at_count   (CW'(gi) == count_reg),
                .tail_pos   (CW'(gi) == tail_idx),
                .left_data  (left_w),
                .right_data (right_w),
                .right_doom (rdoom_w),
                .head_data  (cell_data[0]),
                .chain_in   (chain[gi]),
                .chain_out  (chain[gi+1]),
                .data       (cell_data[gi]),
                .doom       (cell_doom[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        dcnt_next  = dcnt_reg;
        found_next = found_reg;
        rv_next    = 1'b0;
        res_next   = res_reg;
        ctl.op     = CELL_HOLD;
        ctl.value  = cmd.value;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (cmd.opcode)
                        OP_HEAD_INS, OP_TAIL_INS, OP_SORT_INS:
                        begin
                            rv_next = 1'b1;
                            if (full)
                                res_next = make_res('0, 1'b0, 1'b1, count_reg, 1'b1);
                            else
                            begin
                                count_next = count_reg + CW'(1);
                                if (cmd.opcode == OP_HEAD_INS)
                                    ctl.op = CELL_INS_HEAD;
                                else if (cmd.opcode == OP_TAIL_INS)
                                    ctl.op = CELL_INS_TAIL;
                                else
                                    ctl.op = CELL_INS_SORT;
                                res_next = make_res('0, 1'b0, 1'b0, count_next, 1'b1);
                            end
                        end
                        OP_REMOVE, OP_SORT_REM:
                        begin
                            ctl.op     = (cmd.opcode == OP_REMOVE) ? CELL_MARK_ALL
                                                                   : CELL_MARK_SORT;
                            found_next = 1'b0;
                            state_next = S_COMPACT;
                        end
                        OP_DUMP:
                        begin
                            if (count_reg == '0)
                            begin
                                rv_next  = 1'b1;
                                res_next = make_res('0, 1'b0, 1'b0, count_reg, 1'b1);
                            end
                            else
                            begin
                                dcnt_next  = '0;
                                state_next = S_DUMP;
                            end
                        end
                        default:
                        begin
                            rv_next  = 1'b1;
                            res_next = make_res('0, 1'b0, 1'b0, count_reg, 1'b1);
                        end
                    endcase
                end
            end
            S_COMPACT:
            begin
                ctl.op = CELL_COMPACT;
                if (chain[DEPTH].doom)
                begin
                    count_next = count_reg - CW'(1);
                    found_next = 1'b1;
                end
                else
                begin
                    rv_next    = 1'b1;
                    res_next   = make_res('0, found_reg, 1'b0, count_reg, 1'b1);
                    state_next = S_IDLE;
                end
            end
            S_DUMP:
            begin
                ctl.op    = CELL_ROTATE;
                rv_next   = 1'b1;
                dcnt_next = dcnt_reg + CW'(1);
                res_next  = make_res(cell_data[0], 1'b0, 1'b0, count_reg,
                                     dcnt_reg == tail_idx);
                if (dcnt_reg == tail_idx)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            dcnt_reg  <= '0;
            found_reg <= 1'b0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            dcnt_reg  <= dcnt_next;
            found_reg <= found_next;
            rv_reg    <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = rv_reg;
    assign result       = res_reg;

endmodule

### tb/sv/tb_bounded_sorted_list_store.sv
// Self-checking testbench for bounded_sorted_list_store: directed and random list commands.
// Keeps a shadow copy of the list to predict every status and dump result in order.
// Depends on bsls_pkg and the bounded_sorted_list_store RTL.
module tb_bounded_sorted_list_store;
    timeunit 1ns;
    timeprecision 1ps;

    import bsls_pkg::*;

    localparam int DEPTH        = 16;
    localparam int DW           = DATA_W;
    localparam int NUM_ITEMS    = 260;
    localparam int QUIET_TAIL   = 40;
    localparam int STALL_LIMIT  = 400;
    localparam int DRAIN_CYCLES = 24;

    localparam logic [2:0] OP_SPARE_A = 3'd6;
    localparam logic [2:0] OP_SPARE_B = 3'd7;

    localparam logic signed [DW-1:0] WORD_MIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic signed [DW-1:0] WORD_MAX = {1'b0, {(DW-1){1'b1}}};

    typedef struct {
        cmd_t cmd;
        int   gap;
    } queued_cmd_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    cmd_t cmd   = '0;
    logic busy;
    logic result_valid;
    res_t result;

    queued_cmd_t           cmd_backlog [$];
    queued_cmd_t           next_cmd;
    res_t                  due_results [$];
    res_t                  want;
    logic signed [DW-1:0]  shadow_list [$];
    int                    gap_left     = 0;
    int                    n_sent       = 0;
    int                    n_results    = 0;
    int                    n_rejects    = 0;
    int                    n_hits       = 0;
    int                    n_dumped     = 0;
    int                    errors       = 0;
    int                    quiet_cycles = 0;

    bounded_sorted_list_store #(.DEPTH(DEPTH)) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .cmd          (cmd),
        .busy         (busy),
        .result_valid (result_valid),
        .result       (result)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic int gap_for(int idx);
        if (idx >= NUM_ITEMS - QUIET_TAIL || (idx / 30) % 3 == 2)
            return 0;
        if ($urandom_range(0, 9) < 3)
            return $urandom_range(1, 4);
        return 0;
    endfunction

    function automatic logic signed [DW-1:0] pick_val();
        int roll;
        int near;
        roll = $urandom_range(0, 9);
        near = $urandom_range(0, 6);
        if (roll < 7)
            return DW'(near - 3);
        if (roll < 9)
        begin
            case ($urandom_range(0, 3))
                0: return WORD_MIN;
                1: return WORD_MAX;
                2: return '1;
                default: return '0;
            endcase
        end
        return $urandom;
    endfunction

    task automatic add_item(input logic [2:0] op, input logic signed [DW-1:0] val);
        queued_cmd_t q;
        q.cmd.opcode = op;
        q.cmd.value  = val;
        q.gap        = gap_for(cmd_backlog.size());
        cmd_backlog.push_back(q);
    endtask

    // Shadow list update; queues the results that one transaction must produce.
    task automatic apply_list_cmd(input cmd_t c);
        logic signed [DW-1:0] kept [$];
        logic signed [DW-1:0] key;
        res_t                 r;
        logic                 hit;
        logic                 halted;
        int                   pos;
        int                   n;
        int                   i;
        key    = $signed(c.value);
        r      = '0;
        hit    = 1'b0;
        halted = 1'b0;
        if (c.opcode == OP_DUMP && shadow_list.size() != 0)
        begin
            n = shadow_list.size();
            for (i = 0; i < n; i++)
            begin
                r           = '0;
                r.element   = shadow_list[i];
                r.occupancy = OCC_W'(n);
                r.last      = (i == n - 1);
                due_results.push_back(r);
            end
            n_dumped += n;
        end
        else
        begin
            case (c.opcode)
                OP_HEAD_INS, OP_TAIL_INS, OP_SORT_INS:
                begin
                    if (shadow_list.size() >= DEPTH)
                    begin
                        r.rejected = 1'b1;
                        n_rejects++;
                    end
                    else
                    begin
                        if (c.opcode == OP_HEAD_INS || shadow_list.size() == 0)
                            pos = 0;
                        else if (c.opcode == OP_TAIL_INS)
                            pos = shadow_list.size();
                        else if (key <= shadow_list[0])
                            pos = 0;
                        else
                        begin
                            pos = 1;
                            while (pos < shadow_list.size() && shadow_list[pos] < key)
                                pos++;
                        end
                        shadow_list.insert(pos, key);
                    end
                end
                OP_REMOVE:
                begin
                    foreach (shadow_list[j])
                    begin
                        if (shadow_list[j] == key)
                            hit = 1'b1;
                        else
                            kept.push_back(shadow_list[j]);
                    end
                    shadow_list = kept;
                end
                OP_SORT_REM:
                begin
                    while (shadow_list.size() != 0 && shadow_list[0] == key)
                    begin
                        void'(shadow_list.pop_front());
                        hit = 1'b1;
                    end
                    if (shadow_list.size() != 0)
                    begin
                        n = shadow_list.size();
                        kept.push_back(shadow_list[0]);
                        for (i = 1; i < n; i++)
                        begin
                            if (halted || (i >= 2 && shadow_list[i] > key))
                            begin
                                halted = 1'b1;
                                kept.push_back(shadow_list[i]);
                            end
                            else if (shadow_list[i] == key)
                                hit = 1'b1;
                            else
                                kept.push_back(shadow_list[i]);
                        end
                        shadow_list = kept;
                    end
                end
                default: ;
            endcase
            if (hit)
                n_hits++;
            r.found     = hit;
            r.empty_res = (shadow_list.size() == 0);
            r.occupancy = OCC_W'(shadow_list.size());
            r.last      = 1'b1;
            due_results.push_back(r);
        end
    endtask

    task automatic check_field(input string name, input logic [DW-1:0] exp_v,
                               input logic [DW-1:0] act_v);
        if (exp_v !== act_v)
        begin
            errors++;
            $display("t=%0t %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
        end
    endtask

    initial
    begin
        int kind;
        int n;
        int k;
        add_item(OP_DUMP, $urandom);
        add_item(OP_REMOVE, '0);
        add_item(OP_SORT_REM, '0);
        add_item(OP_SPARE_A, '1);
        add_item(OP_SPARE_B, '0);
        add_item(OP_HEAD_INS, WORD_MAX);
        add_item(OP_TAIL_INS, WORD_MIN);
        add_item(OP_SORT_INS, 5);
        add_item(OP_SORT_INS, 9);
        add_item(OP_SORT_INS, 7);
        add_item(OP_SORT_INS, 5);
        add_item(OP_DUMP, $urandom);
        add_item(OP_REMOVE, WORD_MIN);
        add_item(OP_REMOVE, WORD_MIN);
        add_item(OP_HEAD_INS, 5);
        add_item(OP_TAIL_INS, 3);
        add_item(OP_SORT_REM, 5);
        add_item(OP_HEAD_INS, 8);
        add_item(OP_SORT_REM, 7);
        add_item(OP_SORT_REM, 3);
        add_item(OP_SORT_REM, 9);
        add_item(OP_DUMP, $urandom);
        add_item(OP_REMOVE, WORD_MAX);
        add_item(OP_SORT_REM, 8);
        add_item(OP_DUMP, $urandom);
        while (cmd_backlog.size() < NUM_ITEMS)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                for (k = -3; k <= 3; k++)
                    add_item(OP_REMOVE, DW'(k));
                add_item(OP_REMOVE, WORD_MIN);
                add_item(OP_REMOVE, WORD_MAX);
            end
            kind = $urandom_range(0, 5);
            case (kind)
                0, 1:
                begin
                    n = $urandom_range(12, 20);
                    repeat (n) add_item(3'($urandom_range(0, 2)), pick_val());
                end
                2, 3:
                begin
                    n = $urandom_range(3, 18);
                    repeat (n) add_item(OP_SORT_INS, pick_val());
                    n = $urandom_range(1, 5);
                    repeat (n) add_item(OP_SORT_REM, pick_val());
                end
                4:
                begin
                    n = $urandom_range(2, 8);
                    repeat (n) add_item(OP_REMOVE, pick_val());
                end
                default:
                begin
                    n = $urandom_range(2, 6);
                    repeat (n) add_item(3'($urandom_range(0, 7)), $urandom);
                end
            endcase
            add_item(OP_DUMP, $urandom);
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start    <= 1'b0;
            cmd      <= '0;
            gap_left <= 0;
        end
        else
        begin
            if (start && !busy)
            begin
                apply_list_cmd(cmd);
                n_sent++;
            end
            if (!start || !busy)
            begin
                if (gap_left != 0)
                begin
                    start    <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (cmd_backlog.size() != 0)
                begin
                    next_cmd = cmd_backlog.pop_front();
                    cmd      <= next_cmd.cmd;
                    start    <= 1'b1;
                    gap_left <= next_cmd.gap;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            n_results++;
            if (due_results.size() == 0)
            begin
                errors++;
                $display("t=%0t unexpected result: expected none, actual %h", $time, result);
            end
            else
            begin
                want = due_results.pop_front();
                check_field("element", want.element, result.element);
                check_field("found", DW'(want.found), DW'(result.found));
                check_field("rejected", DW'(want.rejected), DW'(result.rejected));
                check_field("empty_res", DW'(want.empty_res), DW'(result.empty_res));
                check_field("occupancy", DW'(want.occupancy), DW'(result.occupancy));
                check_field("last", DW'(want.last), DW'(result.last));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || result_valid)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("t=%0t no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("[bounded_sorted_list_store] ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        @(posedge rst_n);
        while (cmd_backlog.size() != 0 || start || due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Ran %0d commands, checked %0d results (%0d dumped elements).",
                 n_sent, n_results, n_dumped);
        $display("Full-store rejects: %0d, removes that deleted something: %0d.",
                 n_rejects, n_hits);
        if (errors == 0)
            $display("[bounded_sorted_list_store] OK");
        else
            $display("[bounded_sorted_list_store] ERROR");
        $finish;
    end

endmodule
